>>> design/time_of_day_clock_with_key_set_top_defines.svh
// assertion macros for the time of day clock
`ifndef TIME_OF_DAY_CLOCK_WITH_KEY_SET_TOP_DEFINES_SVH
`define TIME_OF_DAY_CLOCK_WITH_KEY_SET_TOP_DEFINES_SVH

// property checked at every clock edge outside reset
`define TODC_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);

// condition in one cycle implies a property in the next
`define TODC_ASSERT_NEXT(label, pre, post, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) pre |=> post) else $error(msg);

`endif

>>> design/todc_pkg.sv
// types and constants of the time of day clock
`default_nettype none
package todc_pkg;

  localparam logic [7:0] TPS_RESET       = 8'd100;
  localparam logic [8:0] ZERO_RATE_LIMIT = 9'd256;
  localparam logic [6:0] SEC_LIMIT       = 7'd60;
  localparam logic [6:0] MIN_LIMIT       = 7'd60;
  localparam logic [5:0] HOUR_LIMIT      = 6'd24;
  localparam logic [6:0] HOUR_SET_LIMIT  = 7'd24;
  localparam logic [6:0] FIELD_MAX       = 7'd59;
  localparam logic [7:0] ASCII_ZERO      = 8'd48;
  localparam logic [7:0] ASCII_NINE      = 8'd57;
  localparam logic [7:0] START_KEY       = 8'h31;
  localparam logic [6:0] DIGIT_WEIGHT    = 7'd10;

  localparam logic MODE_TICK = 1'b0;
  localparam logic MODE_KEY  = 1'b1;

  typedef struct packed {
    logic       mode;
    logic [7:0] key_code;
  } item_t;

  typedef struct packed {
    logic [4:0] hours;
    logic [5:0] minutes;
    logic [5:0] seconds;
    logic [4:0] shown_hours;
    logic [5:0] shown_minutes;
    logic [5:0] shown_seconds;
    logic [1:0] entry_phase;
    logic       entry_error;
  } result_t;

  typedef struct packed {
    logic valid;
    logic advance;
  } flow_t;

endpackage
`default_nettype wire

>>> design/todc_item_if.sv
// input word channel: tick or key press
`default_nettype none
interface todc_item_if;
  logic       valid;
  logic       ready;
  logic       mode;
  logic [7:0] key_code;

  modport source (output valid, output mode, output key_code, input ready);
  modport sink (input valid, input mode, input key_code, output ready);
endinterface
`default_nettype wire

>>> design/todc_result_if.sv
// result word channel: time and entry status
`default_nettype none
interface todc_result_if;
  logic       valid;
  logic       ready;
  logic [4:0] hours;
  logic [5:0] minutes;
  logic [5:0] seconds;
  logic [4:0] shown_hours;
  logic [5:0] shown_minutes;
  logic [5:0] shown_seconds;
  logic [1:0] entry_phase;
  logic       entry_error;

  modport source (
    output valid, output hours, output minutes, output seconds,
    output shown_hours, output shown_minutes, output shown_seconds,
    output entry_phase, output entry_error, input ready
  );
  modport sink (
    input valid, input hours, input minutes, input seconds,
    input shown_hours, input shown_minutes, input shown_seconds,
    input entry_phase, input entry_error, output ready
  );
endinterface
`default_nettype wire

>>> design/todc_cfg_if.sv
// configuration write channel: ticks per second
`default_nettype none
interface todc_cfg_if;
  logic       valid;
  logic       ready;
  logic [7:0] ticks_per_second;

  modport source (output valid, output ticks_per_second, input ready);
  modport sink (input valid, input ticks_per_second, output ready);
endinterface
`default_nettype wire

>>> design/todc_in_stage.sv
// input register of the time of day clock
`default_nettype none
module todc_in_stage
  import todc_pkg::*;
(
  input  wire logic  clk_i,
  input  wire logic  rst_ni,
  todc_item_if.sink  in_i,
  input  wire logic  advance_i,
  output flow_t      flow_o,
  output item_t      item_o
);

  logic  valid_q;
  item_t item_q;
  logic  accept;

  assign in_i.ready = !valid_q || advance_i;
  assign accept     = in_i.valid && in_i.ready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (in_i.ready) begin
      valid_q <= in_i.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      item_q <= '{mode: in_i.mode, key_code: in_i.key_code};
    end
  end

  assign flow_o.valid   = valid_q;
  assign flow_o.advance = valid_q && advance_i;
  assign item_o         = item_q;

endmodule
`default_nettype wire

>>> design/todc_core.sv
// clock counters, rate register and key set sequence
`default_nettype none
`include "time_of_day_clock_with_key_set_top_defines.svh"
module todc_core
  import todc_pkg::*;
(
  input  wire logic clk_i,
  input  wire logic rst_ni,
  todc_cfg_if.sink  cfg_i,
  input  flow_t     flow_i,
  input  item_t     item_i,
  output result_t   res_o
);

  typedef enum logic [1:0] {
    PH_IDLE    = 2'd0,
    PH_HOURS   = 2'd1,
    PH_MINUTES = 2'd2,
    PH_SECONDS = 2'd3
  } phase_e;

  logic [7:0] tps_q;
  logic [7:0] cnt_q, cnt_d;
  logic [5:0] second_q, second_d;
  logic [5:0] minute_q, minute_d;
  logic [4:0] hour_q, hour_d;
  phase_e     phase_q, phase_d;
  logic       have_q, have_d;
  logic [3:0] first_q, first_d;

  logic       step;
  logic       err;
  logic       bad;
  logic       is_digit;
  logic [8:0] limit;
  logic [8:0] cnt_next;
  logic [6:0] sec_w;
  logic [6:0] min_w;
  logic [5:0] hour_w;
  logic [7:0] digit_w;
  logic [6:0] value;

  assign step        = flow_i.advance;
  assign cfg_i.ready = 1'b1;

  assign limit    = (tps_q == 8'd0) ? ZERO_RATE_LIMIT : {1'b0, tps_q};
  assign cnt_next = {1'b0, cnt_q} + 9'd1;
  assign is_digit = (item_i.key_code >= ASCII_ZERO) && (item_i.key_code <= ASCII_NINE);
  assign digit_w  = item_i.key_code - ASCII_ZERO;
  assign value    = {3'b000, first_q} * DIGIT_WEIGHT + {3'b000, digit_w[3:0]};

  always_comb begin
    cnt_d    = cnt_q;
    second_d = second_q;
    minute_d = minute_q;
    hour_d   = hour_q;
    phase_d  = phase_q;
    have_d   = have_q;
    first_d  = first_q;
    err      = 1'b0;
    bad      = 1'b0;
    sec_w    = {1'b0, second_q};
    min_w    = {1'b0, minute_q};
    hour_w   = {1'b0, hour_q};
    if (step) begin
      if (item_i.mode == MODE_TICK) begin
        if (cnt_next >= limit) begin
          cnt_d = 8'd0;
          sec_w = sec_w + 7'd1;
        end else begin
          cnt_d = cnt_next[7:0];
        end
        if (sec_w >= SEC_LIMIT) begin
          sec_w = 7'd0;
          min_w = min_w + 7'd1;
        end
        if (min_w >= MIN_LIMIT) begin
          min_w  = 7'd0;
          hour_w = hour_w + 6'd1;
        end
        if (hour_w >= HOUR_LIMIT) begin
          hour_w = 6'd0;
        end
        second_d = sec_w[5:0];
        minute_d = min_w[5:0];
        hour_d   = hour_w[4:0];
      end else begin
        case (phase_q)
          PH_IDLE: begin
            if (item_i.key_code == START_KEY) begin
              phase_d = PH_HOURS;
              have_d  = 1'b0;
              first_d = 4'd0;
            end
          end
          default: begin
            if (!is_digit) begin
              phase_d = PH_IDLE;
              have_d  = 1'b0;
              err     = 1'b1;
            end else if (!have_q) begin
              first_d = digit_w[3:0];
              have_d  = 1'b1;
            end else begin
              have_d = 1'b0;
              case (phase_q)
                PH_HOURS: begin
                  if (value == HOUR_SET_LIMIT) begin
                    hour_d = 5'd0;
                  end else if (value > HOUR_SET_LIMIT) begin
                    bad = 1'b1;
                  end else begin
                    hour_d = value[4:0];
                  end
                end
                PH_MINUTES: begin
                  if (value > FIELD_MAX) begin
                    bad = 1'b1;
                  end else begin
                    minute_d = value[5:0];
                  end
                end
                default: begin
                  if (value > FIELD_MAX) begin
                    bad = 1'b1;
                  end else begin
                    second_d = value[5:0];
                  end
                end
              endcase
              err = bad;
              if (bad) begin
                phase_d = PH_IDLE;
              end else begin
                case (phase_q)
                  PH_HOURS:   phase_d = PH_MINUTES;
                  PH_MINUTES: phase_d = PH_SECONDS;
                  default:    phase_d = PH_IDLE;
                endcase
              end
            end
          end
        endcase
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tps_q    <= TPS_RESET;
      cnt_q    <= 8'd0;
      second_q <= 6'd0;
      minute_q <= 6'd0;
      hour_q   <= 5'd0;
      phase_q  <= PH_IDLE;
      have_q   <= 1'b0;
      first_q  <= 4'd0;
    end else begin
      if (cfg_i.valid) begin
        tps_q <= cfg_i.ticks_per_second;
      end
      cnt_q    <= cnt_d;
      second_q <= second_d;
      minute_q <= minute_d;
      hour_q   <= hour_d;
      phase_q  <= phase_d;
      have_q   <= have_d;
      first_q  <= first_d;
    end
  end

  always_comb begin
    res_o.hours         = hour_d;
    res_o.minutes       = minute_d;
    res_o.seconds       = second_d;
    res_o.shown_hours   = (phase_d == PH_HOURS) ? 5'd0 : hour_d;
    res_o.shown_minutes = (phase_d == PH_HOURS || phase_d == PH_MINUTES) ? 6'd0 : minute_d;
    res_o.shown_seconds = (phase_d != PH_IDLE) ? 6'd0 : second_d;
    res_o.entry_phase   = phase_d;
    res_o.entry_error   = err;
  end

  `TODC_ASSERT(a_time_range, hour_q < 5'd24 && minute_q < 6'd60 && second_q < 6'd60, "time out of range")
  `TODC_ASSERT(a_idle_no_digit, phase_q == PH_IDLE |-> !have_q, "digit held in idle")
  `TODC_ASSERT(a_err_to_idle, err |-> step && phase_d == PH_IDLE, "error without return to idle")
  `TODC_ASSERT_NEXT(a_hold_state, !step, $stable(hour_q) && $stable(minute_q) && $stable(second_q) && $stable(phase_q) && $stable(cnt_q), "state moved without a word")

endmodule
`default_nettype wire

>>> design/todc_out_stage.sv
// result register of the time of day clock
`default_nettype none
module todc_out_stage
  import todc_pkg::*;
(
  input  wire logic    clk_i,
  input  wire logic    rst_ni,
  input  flow_t        flow_i,
  input  result_t      res_i,
  output logic         advance_o,
  todc_result_if.source out_o
);

  logic    valid_q;
  result_t res_q;

  assign advance_o = !valid_q || out_o.ready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (advance_o) begin
      valid_q <= flow_i.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (flow_i.advance) begin
      res_q <= res_i;
    end
  end

  assign out_o.valid         = valid_q;
  assign out_o.hours         = res_q.hours;
  assign out_o.minutes       = res_q.minutes;
  assign out_o.seconds       = res_q.seconds;
  assign out_o.shown_hours   = res_q.shown_hours;
  assign out_o.shown_minutes = res_q.shown_minutes;
  assign out_o.shown_seconds = res_q.shown_seconds;
  assign out_o.entry_phase   = res_q.entry_phase;
  assign out_o.entry_error   = res_q.entry_error;

endmodule
`default_nettype wire

>>> design/time_of_day_clock_with_key_set_top.sv
// time of day clock with keypad set: top level
// usage:
//   in_i carries one word per tick or key press (mode 0 tick, mode 1 key,
//   key_code ascii). out_o returns exactly one result word per input word:
//   current time, blanked display fields, entry phase and error flag.
//   cfg_i writes ticks_per_second (always ready); write it only while idle.
// path: an accepted word goes through the input register, then the update
//   logic into the result register.
// throughput: one word per cycle while out_o.ready is high; the state
//   update is one pass of counter and digit logic between both registers.
// reset: time 00:00:00, prescaler cleared, entry idle, rate 100 ticks.
// stall: while out_o.ready is low the result is held and one more word
//   can sit in the input register; in_i.ready drops once both are full.
`default_nettype none
module time_of_day_clock_with_key_set_top
  import todc_pkg::*;
(
  input  wire logic     clk_i,
  input  wire logic     rst_ni,
  todc_cfg_if.sink      cfg_i,
  todc_item_if.sink     in_i,
  todc_result_if.source out_o
);

  flow_t   flow;
  item_t   item;
  result_t res;
  logic    advance;

  todc_in_stage u_in_stage (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .in_i      (in_i),
    .advance_i (advance),
    .flow_o    (flow),
    .item_o    (item)
  );

  todc_core u_core (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .cfg_i  (cfg_i),
    .flow_i (flow),
    .item_i (item),
    .res_o  (res)
  );

  todc_out_stage u_out_stage (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .flow_i    (flow),
    .res_i     (res),
    .advance_o (advance),
    .out_o     (out_o)
  );

endmodule
`default_nettype wire
